### hw/rtl/base64_char_decoder_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Base64 character decoder
// Shared helper macros so that every assertion in the project reports alike.
// ----------------------------------------------------------------------------
`ifndef BASE64_CHAR_DECODER_CORE_ASSERT_SVH
`define BASE64_CHAR_DECODER_CORE_ASSERT_SVH

// Property checked at every rising edge of i_clk, switched off while in reset.
`define B64CD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property checked at every rising edge of i_clk, reset cycles included.
`define B64CD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### hw/rtl/b64cd_pkg.sv
// ----------------------------------------------------------------------------
// Base64 character decoder package
// Types, constants and the character-to-sextet mapping used by the decoder.
// ----------------------------------------------------------------------------
package b64cd_pkg;

    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned SEXTET_W  = 6;
    localparam int unsigned GROUP_W   = 4 * SEXTET_W;   // 24 bits, three bytes
    localparam int unsigned ACCUM_W   = 3 * SEXTET_W;   // up to three held sextets
    localparam int unsigned LEN_W     = 16;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'hFFFF;

    // ASCII codes of the character ranges.
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_DIGIT_0 = 8'h30;
    localparam logic [CHAR_W-1:0] CH_DIGIT_9 = 8'h39;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_SLASH   = 8'h2F;

    typedef logic [CHAR_W-1:0]   t_char;
    typedef logic [SEXTET_W-1:0] t_sextet;
    typedef logic [GROUP_W-1:0]  t_group;
    typedef logic [ACCUM_W-1:0]  t_accum;
    typedef logic [LEN_W-1:0]    t_len;

    // Maps one character to its 6-bit value; anything outside the alphabet,
    // the padding character included, maps to zero.
    function automatic t_sextet f_sextet(input t_char c);
        t_char v;
        v = '0;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            v = c - CH_UPPER_A;
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            v = c - CH_LOWER_A + 8'd26;
        end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
            v = c - CH_DIGIT_0 + 8'd52;
        end else if (c == CH_PLUS) begin
            v = 8'd62;
        end else if (c == CH_SLASH) begin
            v = 8'd63;
        end
        return v[SEXTET_W-1:0];
    endfunction

endpackage

### hw/rtl/base64_char_decoder_core.sv
// ----------------------------------------------------------------------------
// Base64 character decoder core
// Decodes a stream of Base64 characters into bytes with a per-string limit.
// ----------------------------------------------------------------------------
// The block takes one Base64 character per transaction on the slave stream
// and gives decoded bytes, one per transaction, on the master stream. Every
// four characters make a group of three bytes; characters outside the
// alphabet, padding included, count as the value zero. The character marked
// by tlast ends the string: an unfinished group is padded with zero values
// and flushed as three bytes, the last of which carries tlast. The number of
// bytes given per string is limited by the max_len register (reset 65535):
// the byte that reaches it carries both tlast and the truncated flag in
// tuser, and the remaining characters of that string, up to and including
// its tlast character, give nothing. A character is accepted in every cycle
// in steady state. Each finished group sits in a three-byte buffer that
// drains one byte per cycle, while the output side is ready, into the
// output register. A character that would complete or flush a group is
// held off while that buffer still holds bytes of the previous group;
// since four characters give three bytes this costs nothing at full rate
// with the output side ready. There is no clearing pass after reset.
// max_len is written on its own channel, which is always ready, and is
// to be changed only while the block is idle; the block does not enforce it.
module base64_char_decoder_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write channel: max_len.
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [b64cd_pkg::LEN_W-1:0]   i_cfg_data,     // [15:0] max_len
    // Character stream.
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [b64cd_pkg::CHAR_W-1:0]  i_s_tdata,      // [7:0] char_code
    input  logic                          i_s_tlast,      // last_char
    // Byte stream.
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [7:0]                    o_m_tdata,      // [7:0] data_byte
    output logic                          o_m_tlast,      // last_byte
    output logic [0:0]                    o_m_tuser       // [0] truncated
);

    // Decoder state for the current string.
    logic [1:0]          r_count, n_count;
    b64cd_pkg::t_accum   r_accum, n_accum;
    b64cd_pkg::t_len     r_given, n_given;
    logic                r_drop,  n_drop;
    b64cd_pkg::t_len     r_max_len;

    // Group buffer: up to three bytes waiting for the output register.
    logic [1:0]          r_pend_cnt, n_pend_cnt;
    b64cd_pkg::t_group   r_pend_word, n_pend_word;
    logic                r_pend_last, n_pend_last;
    logic                r_pend_trunc, n_pend_trunc;

    // Output register.
    logic                r_out_valid, n_out_valid;
    logic [7:0]          r_out_data, n_out_data;
    logic                r_out_last, n_out_last;
    logic                r_out_trunc, n_out_trunc;

    logic                w_in_acc;
    logic                w_gives;
    logic                w_move;
    b64cd_pkg::t_sextet  w_sextet;
    b64cd_pkg::t_group   w_word;
    logic                w_hit0, w_hit1, w_hit2, w_hit;

    assign o_cfg_ready = 1'b1;

    // A character gives bytes when it fills the group or ends the string,
    // unless the rest of a truncated string is being dropped.
    assign w_gives  = !r_drop && ((r_count == 2'd3) || i_s_tlast);
    // Tlast is part of the decision, so ready looks at it: only a character
    // that gives bytes needs the group buffer to be empty.
    assign o_s_tready = (r_pend_cnt == 2'd0) || r_drop
                        || ((r_count != 2'd3) && !i_s_tlast);
    assign w_in_acc = i_s_tvalid && o_s_tready;
    assign w_move   = (r_pend_cnt != 2'd0) && (!r_out_valid || i_m_tready);

    assign w_sextet = b64cd_pkg::f_sextet(i_s_tdata);

    // Place the new sextet and pad an unfinished group with zero values.
    always_comb begin
        case (r_count)
            2'd0:    w_word = {w_sextet, 18'd0};
            2'd1:    w_word = {r_accum[5:0], w_sextet, 12'd0};
            2'd2:    w_word = {r_accum[11:0], w_sextet, 6'd0};
            2'd3:    w_word = {r_accum, w_sextet};
            default: w_word = '0;
        endcase
    end

    // Compare the running byte count against the limit for each of the
    // three bytes of the group at once.
    assign w_hit0 = (r_given + 16'd1) == r_max_len;
    assign w_hit1 = (r_given + 16'd2) == r_max_len;
    assign w_hit2 = (r_given + 16'd3) == r_max_len;
    assign w_hit  = w_hit0 || w_hit1 || w_hit2;

    // Decoder state.
    always_comb begin
        n_count = r_count;
        n_accum = r_accum;
        n_given = r_given;
        n_drop  = r_drop;
        if (w_in_acc) begin
            if (r_drop) begin
                if (i_s_tlast) begin
                    n_count = '0;
                    n_accum = '0;
                    n_given = '0;
                    n_drop  = 1'b0;
                end
            end else if (!w_gives) begin
                n_count = r_count + 2'd1;
                n_accum = {r_accum[11:0], w_sextet};
            end else begin
                n_count = '0;
                n_accum = '0;
                if (w_hit || i_s_tlast) begin
                    n_given = '0;
                end else begin
                    n_given = r_given + 16'd3;
                end
                n_drop = w_hit && !i_s_tlast;
            end
        end
    end

    // Group buffer: loaded from a finished group, drained a byte at a time.
    always_comb begin
        n_pend_cnt   = r_pend_cnt;
        n_pend_word  = r_pend_word;
        n_pend_last  = r_pend_last;
        n_pend_trunc = r_pend_trunc;
        if (w_in_acc && w_gives) begin
            if (w_hit0) begin
                n_pend_cnt = 2'd1;
            end else if (w_hit1) begin
                n_pend_cnt = 2'd2;
            end else begin
                n_pend_cnt = 2'd3;
            end
            n_pend_word  = w_word;
            n_pend_last  = w_hit || i_s_tlast;
            n_pend_trunc = w_hit;
        end else if (w_move) begin
            n_pend_cnt  = r_pend_cnt - 2'd1;
            n_pend_word = {r_pend_word[15:0], 8'd0};
        end
    end

    // Output register: the flags belong to the final byte of the group only.
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        n_out_trunc = r_out_trunc;
        if (w_move) begin
            n_out_valid = 1'b1;
            n_out_data  = r_pend_word[23:16];
            n_out_last  = (r_pend_cnt == 2'd1) && r_pend_last;
            n_out_trunc = (r_pend_cnt == 2'd1) && r_pend_trunc;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_accum     <= '0;
            r_given     <= '0;
            r_drop      <= 1'b0;
            r_max_len   <= b64cd_pkg::MAX_LEN_RESET;
            r_pend_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_accum     <= n_accum;
            r_given     <= n_given;
            r_drop      <= n_drop;
            r_pend_cnt  <= n_pend_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_max_len <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_word  <= n_pend_word;
        r_pend_last  <= n_pend_last;
        r_pend_trunc <= n_pend_trunc;
        r_out_data   <= n_out_data;
        r_out_last   <= n_out_last;
        r_out_trunc  <= n_out_trunc;
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = r_out_data;
    assign o_m_tlast    = r_out_last;
    assign o_m_tuser[0] = r_out_trunc;

endmodule

### hw/rtl/b64cd_checker.sv
// ----------------------------------------------------------------------------
// Base64 character decoder port checker
// Watches the ports of the decoder core over time and flags violations.
// ----------------------------------------------------------------------------
`include "base64_char_decoder_core_assert.svh"

module b64cd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_s_tready,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [7:0]                    o_m_tdata,
    input logic                          o_m_tlast,
    input logic [0:0]                    o_m_tuser
);

    // A stalled byte transaction keeps its contents.
    `B64CD_ASSERT(a_out_hold, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast) && $stable(o_m_tuser), "stalled output byte changed")

    // A truncated byte is always the last byte of its string.
    `B64CD_ASSERT(a_trunc_is_last, o_m_tvalid && o_m_tuser[0] |-> o_m_tlast, "truncated byte without tlast")

    // Reset leaves no byte on the output.
    `B64CD_ASSERT_ALWAYS(a_reset_out, !i_rst_n |=> !o_m_tvalid, "output valid after reset")

    // Reset leaves the decoder ready for a character.
    `B64CD_ASSERT_ALWAYS(a_reset_ready, !i_rst_n |=> o_s_tready, "input not ready after reset")

endmodule

bind base64_char_decoder_core b64cd_checker u_b64cd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);

### test/tb.sv
// ----------------------------------------------------------------------------
// Testbench for the Base64 character decoder core
// Feeds character strings through the slave stream and checks every decoded
// byte on the master stream against a behavioural copy of the decoder, under
// several max_len settings and with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb;

    localparam int HALF_PERIOD     = 6;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int TAIL_CYCLES     = 16;
    localparam int NUM_PHASES      = 7;
    localparam int ITEMS_PER_PHASE = 34;
    localparam int IDLE_PERCENT    = 25;

    // One decoded byte as it leaves the block.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       trunc;
    } t_dec_byte;

    // One line of the directed table: either a max_len write or a character,
    // optionally with the bytes it gives written out by hand.
    typedef struct packed {
        logic            is_cfg;
        logic [15:0]     value;
        logic            last;
        logic            typed;
        logic [1:0]      n_typed;
        t_dec_byte [2:0] bytes;
    } t_dir_row;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    b64cd_pkg::t_len   cfg_data  = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    b64cd_pkg::t_char  s_tdata   = '0;
    logic              s_tlast   = 1'b0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [7:0]        m_tdata;
    logic              m_tlast;
    logic [0:0]        m_tuser;

    // No idling on either stream while this is set.
    logic        calm      = 1'b0;
    int          fails     = 0;
    int          cycles    = 0;

    // Bytes still owed by the block, oldest first.
    t_dec_byte   byte_q[$];
    t_dir_row    dir_rows[$];

    // Decoder state as the block should hold it.
    b64cd_pkg::t_len model_max_len;
    logic [1:0]      grp_count;
    logic [17:0]     grp_accum;
    b64cd_pkg::t_len bytes_out;
    logic            dropping;

    base64_char_decoder_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tlast   (s_tlast),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tlast   (m_tlast),
        .o_m_tuser   (m_tuser)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic void clear_string();
        grp_count = '0;
        grp_accum = '0;
        bytes_out = '0;
        dropping  = 1'b0;
    endfunction

    // Works out the bytes that one accepted character gives and advances the
    // decoder state.
    task automatic decode_char(input b64cd_pkg::t_char c, input logic is_last,
                               output t_dec_byte [2:0] res, output int n);
        b64cd_pkg::t_char v;
        logic [5:0]  sx;
        logic [23:0] acc;
        logic [23:0] word;
        logic [2:0]  cnt;
        logic        hit;
        logic        done;
        res  = '0;
        n    = 0;
        v    = '0;
        done = 1'b0;
        if (c >= "A" && c <= "Z") begin
            v = c - "A";
        end else if (c >= "a" && c <= "z") begin
            v = c - "a" + 8'd26;
        end else if (c >= "0" && c <= "9") begin
            v = c - "0" + 8'd52;
        end else if (c == "+") begin
            v = 8'd62;
        end else if (c == "/") begin
            v = 8'd63;
        end
        sx = v[5:0];
        if (dropping) begin
            // The rest of a truncated string gives nothing; its end clears.
            if (is_last) begin
                clear_string();
            end
        end else begin
            acc = {grp_accum, sx};
            cnt = {1'b0, grp_count} + 3'd1;
            if (cnt < 3'd4 && !is_last) begin
                grp_accum = acc[17:0];
                grp_count = cnt[1:0];
            end else begin
                // A short group at the end of a string is padded with zeros.
                word      = acc << (6 * (4 - cnt));
                grp_accum = '0;
                grp_count = '0;
                for (int i = 0; i < 3; i++) begin
                    if (!done) begin
                        bytes_out      = bytes_out + 16'd1;
                        hit            = (bytes_out == model_max_len);
                        res[n].data    = word[23 - 8*i -: 8];
                        res[n].last    = hit || (is_last && i == 2);
                        res[n].trunc   = hit;
                        n++;
                        if (hit) begin
                            bytes_out = '0;
                            dropping  = !is_last;
                            done      = 1'b1;
                        end
                    end
                end
                if (is_last) begin
                    clear_string();
                end
            end
        end
    endtask

    // Offers one character, waits for its transaction and records what it
    // should give. Called and returns just after a falling edge.
    task automatic send_char(input b64cd_pkg::t_char c, input logic is_last,
                             input logic typed, input logic [1:0] n_typed,
                             input t_dec_byte [2:0] typed_bytes);
        t_dec_byte [2:0] res;
        int              n;
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= is_last;
        do @(posedge clk); while (!s_tready);
        decode_char(c, is_last, res, n);
        if (typed) begin
            res = typed_bytes;
            n   = n_typed;
        end
        for (int k = 0; k < n; k++) begin
            byte_q.push_back(res[k]);
        end
        @(negedge clk);
    endtask

    // Stops sending and waits until every owed byte has come out, then lets
    // the pipeline settle.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (byte_q.size() != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_max_len(input b64cd_pkg::t_len v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        model_max_len = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic void add_char(input b64cd_pkg::t_char c, input logic is_last);
        t_dir_row row;
        row       = '0;
        row.value = {8'd0, c};
        row.last  = is_last;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_typed(input b64cd_pkg::t_char c, input logic is_last,
                                      input logic [1:0] n,
                                      input t_dec_byte b0, input t_dec_byte b1,
                                      input t_dec_byte b2);
        t_dir_row row;
        row          = '0;
        row.value    = {8'd0, c};
        row.last     = is_last;
        row.typed    = 1'b1;
        row.n_typed  = n;
        row.bytes[0] = b0;
        row.bytes[1] = b1;
        row.bytes[2] = b2;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_cfg(input b64cd_pkg::t_len v);
        t_dir_row row;
        row        = '0;
        row.is_cfg = 1'b1;
        row.value  = v;
        dir_rows.push_back(row);
    endfunction

    // The receiver stalls at random except during the calm stretch.
    always @(negedge clk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Every byte transaction is matched against the oldest owed byte.
    always @(posedge clk) begin : byte_check
        t_dec_byte want;
        if (rst_n && m_tvalid && m_tready) begin
            if (byte_q.size() == 0) begin
                $error("byte 0x%02h given with none expected", m_tdata);
                fails++;
            end else begin
                want = byte_q.pop_front();
                if (m_tdata !== want.data) begin
                    $error("data_byte: expected 0x%02h, got 0x%02h", want.data, m_tdata);
                    fails++;
                end
                if (m_tlast !== want.last) begin
                    $error("last_byte: expected %0b, got %0b", want.last, m_tlast);
                    fails++;
                end
                if (m_tuser[0] !== want.trunc) begin
                    $error("truncated: expected %0b, got %0b", want.trunc, m_tuser[0]);
                    fails++;
                end
            end
        end
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("tb NOT OK");
        $finish;
    end

    initial begin : stimulus
        t_dir_row         row;
        b64cd_pkg::t_len  phase_max[NUM_PHASES];
        b64cd_pkg::t_char c;
        int               sent;
        int               slen;
        int               pick;
        int               idx;
        logic             paused;

        model_max_len = b64cd_pkg::MAX_LEN_RESET;
        clear_string();
        paused = 1'b0;

        // Directed table. With max_len at its reset value a plain group,
        // the all-ones extreme, invalid and padding characters, and a single
        // character flushed at the end of a string.
        add_char("T", 1'b0);
        add_char("W", 1'b0);
        add_char("F", 1'b0);
        add_typed("u", 1'b0, 2'd3, {8'h4D, 1'b0, 1'b0}, {8'h61, 1'b0, 1'b0},
                  {8'h6E, 1'b0, 1'b0});
        add_char("/", 1'b0);
        add_char("/", 1'b0);
        add_char("/", 1'b0);
        add_typed("/", 1'b1, 2'd3, {8'hFF, 1'b0, 1'b0}, {8'hFF, 1'b0, 1'b0},
                  {8'hFF, 1'b1, 1'b0});
        add_char("=", 1'b0);
        add_char(8'hFF, 1'b0);
        add_char(8'h00, 1'b0);
        add_char("z", 1'b1);
        add_typed("Q", 1'b1, 2'd3, {8'h40, 1'b0, 1'b0}, {8'h00, 1'b0, 1'b0},
                  {8'h00, 1'b1, 1'b0});
        // Smallest limit: the first byte truncates and the rest of the string
        // is dropped; then a limit hit on the character that ends the string.
        add_cfg(16'd1);
        add_char("T", 1'b0);
        add_char("W", 1'b0);
        add_char("F", 1'b0);
        add_typed("u", 1'b0, 2'd1, {8'h4D, 1'b1, 1'b1}, '0, '0);
        add_typed("A", 1'b0, 2'd0, '0, '0, '0);
        add_typed("B", 1'b1, 2'd0, '0, '0, '0);
        add_char("Q", 1'b0);
        add_typed("Q", 1'b1, 2'd1, {8'h41, 1'b1, 1'b1}, '0, '0);
        // The limit falls on the final byte of a flushed group.
        add_cfg(16'd3);
        add_char("0", 1'b0);
        add_char("9", 1'b0);
        add_char("a", 1'b0);
        add_char("z", 1'b1);

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[r]) begin
            row = dir_rows[r];
            if (row.is_cfg) begin
                wait_for_drain();
                write_max_len(row.value);
            end else begin
                send_char(row.value[7:0], row.last, row.typed, row.n_typed, row.bytes);
            end
        end

        // Random part: mostly whole strings of alphabet characters with some
        // padding and stray codes mixed in, plus lone random characters.
        phase_max[0] = 16'd1;
        phase_max[1] = 16'hFFFF;
        phase_max[2] = 16'd2;
        phase_max[3] = b64cd_pkg::t_len'($urandom_range(3, 12));
        phase_max[4] = b64cd_pkg::t_len'($urandom_range(1, 65535));
        phase_max[5] = b64cd_pkg::t_len'($urandom_range(4, 40));
        phase_max[6] = 16'hFFFF;

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_for_drain();
            write_max_len(phase_max[p]);
            calm = (p == 1);
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                if (p == 4 && sent >= ITEMS_PER_PHASE / 2 && !paused) begin
                    // Hold the sender off until the block has emptied.
                    wait_for_drain();
                    paused = 1'b1;
                end
                if ($urandom_range(0, 99) < 80) begin
                    slen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 24)
                                                       : $urandom_range(1, 12);
                    for (int k = 0; k < slen; k++) begin
                        pick = $urandom_range(0, 99);
                        if (pick < 85) begin
                            idx = $urandom_range(0, 63);
                            if (idx < 26) begin
                                c = b64cd_pkg::t_char'("A" + idx);
                            end else if (idx < 52) begin
                                c = b64cd_pkg::t_char'("a" + (idx - 26));
                            end else if (idx < 62) begin
                                c = b64cd_pkg::t_char'("0" + (idx - 52));
                            end else if (idx == 62) begin
                                c = "+";
                            end else begin
                                c = "/";
                            end
                        end else if (pick < 90) begin
                            c = "=";
                        end else begin
                            c = b64cd_pkg::t_char'($urandom_range(0, 255));
                        end
                        send_char(c, k == slen - 1, 1'b0, 2'd0, '0);
                    end
                    sent += slen;
                end else begin
                    send_char(b64cd_pkg::t_char'($urandom_range(0, 255)),
                              $urandom_range(0, 3) == 0, 1'b0, 2'd0, '0);
                    sent++;
                end
            end
        end
        calm = 1'b0;

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fails == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/b64cd_pkg.sv
hw/rtl/base64_char_decoder_core.sv
hw/rtl/b64cd_checker.sv
test/tb.sv
